[design/bmpc_pkg.sv]
`timescale 1ns / 1ps
// Package for the blind motor position controller.
// Holds request codes, state and direction encodings and shared structs.
package bmpc_pkg;

  localparam logic [2:0] REQ_HALL  = 3'd0;
  localparam logic [2:0] REQ_MS    = 3'd1;
  localparam logic [2:0] REQ_SPEED = 3'd2;
  localparam logic [2:0] REQ_START = 3'd3;
  localparam logic [2:0] REQ_STOP  = 3'd4;
  localparam logic [2:0] REQ_SETLOC = 3'd5;

  localparam logic [2:0] ST_STOPPED  = 3'd0;
  localparam logic [2:0] ST_MOVING   = 3'd1;
  localparam logic [2:0] ST_STOPPING = 3'd2;
  localparam logic [2:0] ST_ENDCAL   = 3'd3;
  localparam logic [2:0] ST_ERROR    = 3'd4;

  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_DOWN = 2'd2;

  localparam logic [2:0] PHASE_INVALID = 3'd4;

  localparam logic [2:0] CFG_SLOWDOWN = 3'd0;
  localparam logic [2:0] CFG_MINSPD   = 3'd1;
  localparam logic [2:0] CFG_GRACE    = 3'd2;
  localparam logic [2:0] CFG_STALL    = 3'd3;
  localparam logic [2:0] CFG_STOPTO   = 3'd4;
  localparam logic [2:0] CFG_SETTLE   = 3'd5;

  localparam int IN_W = 47;

  typedef struct packed {
    logic [2:0]  req_type;
    logic        hall_sensor;
    logic        hall_level;
    logic        move_dir;
    logic [7:0]  start_speed;
    logic signed [15:0] target_loc;
    logic signed [15:0] new_location;
    logic        set_calibrating;
  } req_t;

  typedef struct packed {
    logic [1:0]  drive_dir;
    logic [7:0]  pwm_duty;
    logic [2:0]  motor_state;
    logic signed [15:0] cur_location;
    logic [7:0]  rpm_estimate;
    logic        is_calibrating;
  } res_t;

endpackage

[design/bmpc_fifo.sv]
`timescale 1ns / 1ps
// Two-entry request queue between the front and back parts.
// Uses bmpc_pkg for the request struct.
module bmpc_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  bmpc_pkg::req_t   wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output bmpc_pkg::req_t   rd_data
);
  import bmpc_pkg::*;

  req_t       mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       wr_en, rd_en;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign wr_en    = wr_valid && wr_ready;
  assign rd_en    = rd_valid && rd_ready;

  always_comb begin
    wp_nxt  = wp_r ^ wr_en;
    rp_nxt  = rp_r ^ rd_en;
    cnt_nxt = cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("queue count out of range");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |-> !wr_ready) else $error("queue accepts when full");
  a_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0 || cnt_r == 2'd2) |-> wp_r == rp_r) else $error("pointer mismatch");
`endif
endmodule

[design/bmpc_front.sv]
`timescale 1ns / 1ps
// Front part: accepts input transfers and unpacks them.
// Uses bmpc_pkg for the request struct and codes.
module bmpc_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [47:0]    in_tdata,
  output logic           q_valid,
  input  logic           q_ready,
  output bmpc_pkg::req_t q_data
);
  import bmpc_pkg::*;

  req_t r;

  always_comb begin
    r.req_type        = in_tdata[2:0];
    r.hall_sensor     = in_tdata[3];
    r.hall_level      = in_tdata[4];
    r.move_dir        = in_tdata[5];
    r.start_speed     = in_tdata[13:6];
    r.target_loc      = in_tdata[29:14];
    r.new_location    = in_tdata[45:30];
    r.set_calibrating = in_tdata[46];
  end

  assign in_tready = q_ready;
  assign q_valid   = in_tvalid;
  assign q_data    = r;

`ifndef SYNTHESIS
  a_pass: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid && q_ready |-> in_tvalid && in_tready) else $error("lost transfer");
  a_type: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid |-> q_data.req_type == in_tdata[2:0]) else $error("bad unpack");
  a_tgt: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid |-> q_data.target_loc == in_tdata[29:14]) else $error("bad unpack");
`endif
endmodule

[design/bmpc_back.sv]
`timescale 1ns / 1ps
// Back part: the controller state, a serial divider for rpm and slowdown, and the
// output register. Uses bmpc_pkg for codes and the request and result structs.
module bmpc_back #(
  parameter int MOTOR_REDUCTION = 171,
  parameter int START_DUTY      = 60
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  output logic           q_ready,
  input  bmpc_pkg::req_t q_data,
  input  logic [7:0]     approach_scale,
  input  logic [7:0]     min_approach_speed,
  input  logic [15:0]    grace_ms,
  input  logic [15:0]    stall_timeout_ms,
  input  logic [15:0]    stopping_timeout_ms,
  input  logic [15:0]    endpoint_settle_ms,
  output logic           res_valid,
  input  logic           res_ready,
  output bmpc_pkg::res_t res_data
);
  import bmpc_pkg::*;

  localparam logic [15:0] RPM_NUM = 16'((60 * 1000) / MOTOR_REDUCTION);
  localparam logic [7:0]  SDUTY   = 8'(START_DUTY);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_DIV1 = 6'b000010, S_DIV2 = 6'b000100,
    S_EXEC = 6'b001000, S_DIV3 = 6'b010000, S_OUT  = 6'b100000
  } fsm_t;

  fsm_t state_r, state_nxt;

  logic signed [15:0] loc_r, loc_nxt, tgt_r, tgt_nxt;
  logic [2:0]  run_r, run_nxt, ph_r, ph_nxt;
  logic [1:0]  dir_r, dir_nxt, ec_r, ec_nxt;
  logic [7:0]  goal_r, goal_nxt, duty_r, duty_nxt, rpm_r, rpm_nxt;
  logic [15:0] hi_r, hi_nxt, idle_r, idle_nxt, runms_r, runms_nxt, set_r, set_nxt;
  logic        cal_r, cal_nxt;

  // Shared restoring divider: 24-bit dividend, 17-bit divisor.
  logic [23:0] dq_r, dq_nxt;
  logic [16:0] drem_r, drem_nxt, dden_r, dden_nxt;
  logic [4:0]  dcnt_r, dcnt_nxt;
  logic        dbusy;
  logic [17:0] dtrial;
  logic [23:0] slow_thr_r, slow_thr_nxt;
  logic [15:0] dist_r, dist_nxt;

  res_t out_r, out_nxt;
  logic ov_r, ov_nxt;

  assign q_ready   = (state_r == S_IDLE) && !ov_r;
  assign res_valid = ov_r;
  assign res_data  = out_r;
  assign dbusy     = (dcnt_r != 5'd0);
  assign dtrial    = {drem_r, dq_r[23]} - {1'b0, dden_r};

  function automatic logic [15:0] inc16(input logic [15:0] v);
    inc16 = (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic logic signed [15:0] sat_add(input logic signed [15:0] v,
                                                 input logic up);
    logic signed [16:0] s;
    s = up ? 17'(v) - 17'sd1 : 17'(v) + 17'sd1;
    if (s > 17'sd32767) sat_add = 16'sh7FFF;
    else if (s < -17'sd32768) sat_add = 16'sh8000;
    else sat_add = s[15:0];
  endfunction

  always_comb begin
    logic [2:0]  np;
    logic [1:0]  d;
    logic        do_tick, up;
    logic signed [16:0] lm, dd;
    logic [7:0]  sp, diff, ns;
    logic [2:0]  st;
    logic [1:0]  dr;
    state_nxt = state_r;
    loc_nxt = loc_r; tgt_nxt = tgt_r; run_nxt = run_r; dir_nxt = dir_r;
    goal_nxt = goal_r; duty_nxt = duty_r; ph_nxt = ph_r; ec_nxt = ec_r;
    hi_nxt = hi_r; idle_nxt = idle_r; runms_nxt = runms_r; set_nxt = set_r;
    cal_nxt = cal_r; rpm_nxt = rpm_r;
    dq_nxt = dq_r; drem_nxt = drem_r; dden_nxt = dden_r; dcnt_nxt = dcnt_r;
    slow_thr_nxt = slow_thr_r; dist_nxt = dist_r;
    out_nxt = out_r; ov_nxt = ov_r;
    np = 3'd0; d = 2'd0; do_tick = 1'b0; up = 1'b0; lm = '0; dd = '0;
    sp = rpm_r; diff = 8'd0; ns = 8'd0; st = run_r; dr = dir_r;
    if (ov_r && res_ready) ov_nxt = 1'b0;
    if (dbusy) begin
      dcnt_nxt = dcnt_r - 5'd1;
      if (!dtrial[17]) begin
        drem_nxt = dtrial[16:0];
        dq_nxt = {dq_r[22:0], 1'b1};
      end else begin
        drem_nxt = {drem_r[15:0], dq_r[23]};
        dq_nxt = {dq_r[22:0], 1'b0};
      end
    end
    case (state_r)
      S_IDLE: begin
        if (q_valid && q_ready) begin
          state_nxt = S_EXEC;
          case (q_data.req_type)
            REQ_HALL: begin
              np = {1'b0, ~q_data.hall_level, q_data.hall_sensor};
              if (!q_data.hall_sensor) begin
                if (ec_r < 2'd2) ec_nxt = ec_r + 2'd1;
                if (ec_r != 2'd0) hi_nxt = idle_r;
                idle_nxt = 16'd0;
              end
              if (ph_r < PHASE_INVALID) begin
                d = np[1:0] - ph_r[1:0];
                if (d == 2'd1 && dir_r != DIR_DOWN) begin do_tick = 1'b1; up = 1'b1; end
                if (d == 2'd3 && dir_r != DIR_UP) begin do_tick = 1'b1; up = 1'b0; end
              end
              ph_nxt = np;
              if (do_tick && !cal_r) begin
                loc_nxt = sat_add(loc_r, up);
                lm = up ? 17'(loc_nxt) - 17'sd1 : 17'(loc_nxt) + 17'sd1;
                if (up && dir_r == DIR_UP && tgt_r != -16'sd1 && lm <= 17'(tgt_r)) begin
                  run_nxt = ST_STOPPED; dir_nxt = DIR_NONE; duty_nxt = 8'd0;
                  hi_nxt = 16'd0; ec_nxt = 2'd0; idle_nxt = 16'd0; goal_nxt = 8'd0;
                end else if (!up && dir_r == DIR_DOWN && lm >= 17'(tgt_r)) begin
                  run_nxt = ST_STOPPED; dir_nxt = DIR_NONE; duty_nxt = 8'd0;
                  hi_nxt = 16'd0; ec_nxt = 2'd0; idle_nxt = 16'd0; goal_nxt = 8'd0;
                end else if (dir_r != DIR_NONE && approach_scale != 8'd0) begin
                  dd = 17'(tgt_r) - 17'(loc_nxt);
                  if (dd < 0) dd = -dd;
                  dist_nxt = dd[15:0];
                  if (dd[16]) dist_nxt = 16'hFFFF;
                  // Threshold goal*factor/8 is the product shifted down by three.
                  slow_thr_nxt = 24'(goal_r) * 24'(approach_scale);
                  state_nxt = S_DIV3;
                  dq_nxt = {4'd0, dd[16:0], 3'b000};
                  drem_nxt = 17'd0;
                  dden_nxt = {9'd0, approach_scale};
                  dcnt_nxt = 5'd24;
                end
              end
            end
            REQ_MS: begin
              if (run_r == ST_MOVING || run_r == ST_STOPPING) begin
                idle_nxt = inc16(idle_r);
                runms_nxt = inc16(runms_r);
                if (runms_nxt > grace_ms && idle_nxt > stall_timeout_ms &&
                    !(run_r == ST_STOPPING && idle_nxt < stopping_timeout_ms)) begin
                  st = run_r; dr = dir_r;
                  run_nxt = ST_STOPPED; dir_nxt = DIR_NONE; duty_nxt = 8'd0;
                  hi_nxt = 16'd0; ec_nxt = 2'd0; goal_nxt = 8'd0;
                  idle_nxt = 16'd0;
                  if (st == ST_MOVING) begin
                    if (dr == DIR_UP) begin run_nxt = ST_ENDCAL; set_nxt = 16'd0; end
                    else run_nxt = ST_ERROR;
                  end
                end
              end else if (run_r == ST_ENDCAL) begin
                set_nxt = inc16(set_r);
                if (set_nxt > endpoint_settle_ms) begin
                  run_nxt = ST_STOPPED; cal_nxt = 1'b0; loc_nxt = 16'sd0;
                end
              end
            end
            REQ_SPEED: begin
              if (run_r == ST_MOVING || run_r == ST_STOPPING) begin
                if (sp < goal_r && duty_r < 8'd254) begin
                  diff = goal_r - sp;
                  duty_nxt = duty_r + ((diff > 8'd2) ? 8'd2 : 8'd1);
                end
                if (sp > goal_r && duty_r > 8'd1) begin
                  diff = sp - goal_r;
                  if (diff > 8'd4) duty_nxt = (duty_r > 8'd2) ? duty_r - 8'd3 : 8'd0;
                  else if (diff > 8'd2) duty_nxt = duty_r - 8'd2;
                  else duty_nxt = duty_r - 8'd1;
                end
              end
            end
            REQ_START: begin
              hi_nxt = 16'd0; ec_nxt = 2'd0; idle_nxt = 16'd0; runms_nxt = 16'd0;
              goal_nxt = q_data.start_speed; duty_nxt = SDUTY;
              run_nxt = ST_MOVING;
              dir_nxt = q_data.move_dir ? DIR_DOWN : DIR_UP;
              tgt_nxt = q_data.target_loc;
            end
            REQ_STOP: begin
              run_nxt = ST_STOPPED; dir_nxt = DIR_NONE; duty_nxt = 8'd0;
              hi_nxt = 16'd0; ec_nxt = 2'd0; idle_nxt = 16'd0; goal_nxt = 8'd0;
            end
            REQ_SETLOC: begin
              loc_nxt = q_data.new_location; cal_nxt = q_data.set_calibrating;
            end
            default: ;
          endcase
        end
      end
      S_DIV3: begin
        if (!dbusy) begin
          // Quotient of dist*8/factor.
          if ({5'd0, dist_r} < slow_thr_r[23:3]) begin
            if (dq_r[23:8] != 16'd0) ns = 8'hFF;
            else if (dq_r[7:0] < min_approach_speed) ns = min_approach_speed;
            else ns = dq_r[7:0];
            run_nxt = ST_STOPPING;
            if (dq_r[23:8] == 16'd0 && ns < goal_r) goal_nxt = ns;
          end
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        // Start the rpm division 60000/ratio/interval/2, or set rpm to zero if no interval is known.
        if (hi_r == 16'd0) begin
          rpm_nxt = 8'd0;
          state_nxt = S_OUT;
        end else begin
          dq_nxt = {8'd0, RPM_NUM};
          drem_nxt = 17'd0;
          dden_nxt = {hi_r, 1'b0};
          dcnt_nxt = 5'd24;
          state_nxt = S_DIV1;
        end
      end
      S_DIV1: begin
        if (!dbusy) begin
          rpm_nxt = (dq_r[23:8] != 16'd0) ? 8'hFF : dq_r[7:0];
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!ov_r || res_ready) begin
          out_nxt.drive_dir = dir_r;
          out_nxt.pwm_duty = (dir_r != DIR_NONE) ? duty_r : 8'd0;
          out_nxt.motor_state = run_r;
          out_nxt.cur_location = loc_r;
          out_nxt.rpm_estimate = rpm_r;
          out_nxt.is_calibrating = cal_r;
          ov_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      loc_r <= '0; tgt_r <= '0; run_r <= ST_STOPPED; dir_r <= DIR_NONE;
      goal_r <= '0; duty_r <= '0; ph_r <= PHASE_INVALID; ec_r <= '0;
      hi_r <= '0; idle_r <= '0; runms_r <= '0; set_r <= '0; cal_r <= 1'b0;
      rpm_r <= '0; dcnt_r <= '0; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      loc_r <= loc_nxt; tgt_r <= tgt_nxt; run_r <= run_nxt; dir_r <= dir_nxt;
      goal_r <= goal_nxt; duty_r <= duty_nxt; ph_r <= ph_nxt; ec_r <= ec_nxt;
      hi_r <= hi_nxt; idle_r <= idle_nxt; runms_r <= runms_nxt; set_r <= set_nxt;
      cal_r <= cal_nxt; rpm_r <= rpm_nxt; dcnt_r <= dcnt_nxt; ov_r <= ov_nxt;
    end
    dq_r <= dq_nxt; drem_r <= drem_nxt; dden_r <= dden_nxt;
    slow_thr_r <= slow_thr_nxt; dist_r <= dist_nxt; out_r <= out_nxt;
  end

`ifndef SYNTHESIS
  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state not one-hot");
  a_duty_off: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res_data.drive_dir == DIR_NONE |-> res_data.pwm_duty == 8'd0)
    else $error("duty while off");
  a_dir_state: assert property (@(posedge clk) disable iff (!rst_n)
    dir_r != DIR_NONE |-> run_r == ST_MOVING || run_r == ST_STOPPING)
    else $error("direction without run");
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !dbusy) else $error("divider busy while idle");
`endif
endmodule

[design/blind_motor_position_controller.sv]
`timescale 1ns / 1ps
// Blind motor position controller: takes hall edges, ms and speed ticks, start,
// stop and set-location requests and returns one status transfer per request.
// The rpm division is skipped while the hall interval is unknown, and a hall tick
// may run the approach slowdown division first; the serial 24-step divider is
// shared by the slowdown and rpm computations. A new request is taken only once
// the status of the last one has been accepted. Uses bmpc_pkg, bmpc_front,
// bmpc_fifo, bmpc_back.
module blind_motor_position_controller #(
  parameter int MOTOR_REDUCTION = 171,
  parameter int START_DUTY      = 60
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // req_type[2:0], hall_sensor, hall_level, move_dir, start_speed[7:0],
  // target_loc[15:0], new_location[15:0], set_calibrating, zero pad
  input  logic [47:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // drive_dir[1:0], pwm_duty[7:0], motor_state[2:0], cur_location[15:0],
  // rpm_estimate[7:0], is_calibrating, zero pad
  output logic [39:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import bmpc_pkg::*;

  logic [7:0]  sf_r, ms_r;
  logic [15:0] gr_r, st_r, so_r, es_r;
  logic        fv, fr, bv, br, rv;
  req_t        fd, bd;
  res_t        rd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sf_r <= 8'd8; ms_r <= 8'd10; gr_r <= 16'd1000;
      st_r <= 16'd200; so_r <= 16'd1000; es_r <= 16'd1000;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SLOWDOWN: sf_r <= cfg_data[7:0];
        CFG_MINSPD:   ms_r <= cfg_data[7:0];
        CFG_GRACE:    gr_r <= cfg_data;
        CFG_STALL:    st_r <= cfg_data;
        CFG_STOPTO:   so_r <= cfg_data;
        CFG_SETTLE:   es_r <= cfg_data;
        default: ;
      endcase
    end
  end

  bmpc_front u_front (.clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .q_valid(fv), .q_ready(fr), .q_data(fd));
  bmpc_fifo u_fifo (.clk, .rst_n, .wr_valid(fv), .wr_ready(fr), .wr_data(fd),
    .rd_valid(bv), .rd_ready(br), .rd_data(bd));
  bmpc_back #(.MOTOR_REDUCTION(MOTOR_REDUCTION), .START_DUTY(START_DUTY)) u_back (
    .clk, .rst_n, .q_valid(bv), .q_ready(br), .q_data(bd),
    .approach_scale(sf_r), .min_approach_speed(ms_r), .grace_ms(gr_r),
    .stall_timeout_ms(st_r), .stopping_timeout_ms(so_r), .endpoint_settle_ms(es_r),
    .res_valid(rv), .res_ready(out_tready), .res_data(rd));

  assign out_tvalid = rv;
  assign out_tdata  = {2'b00, rd.is_calibrating, rd.rpm_estimate, rd.cur_location,
                       rd.motor_state, rd.pwm_duty, rd.drive_dir};

`ifndef SYNTHESIS
  a_cfg: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("config not ready");
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[39:38] == 2'b00) else $error("pad bits set");
  a_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[12:10] <= 3'd4) else $error("bad state");
`endif
endmodule
